@@ rtl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned Entries   = 16;
  localparam int unsigned CountBits = 16;
  localparam int unsigned CapW      = 5;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_e;

endpackage

@@ rtl/lfu_cache_table.sv @@
// Steps: a match pass over the memory, a victim pass when a put must evict, an update pass,
// write-back and the result. A get miss or an ignored put skips the update pass.
// A new request is taken only while idle; busy is low again when done_o is high.
// Reset clears the valid bits and sets capacity to 16; memories are not cleared.
// The receiver cannot stall: done_o stands for one cycle and marks the result.
// ----------------------------------------------------------------------------
// lfu_cache_table
// LFU cache with LRU tiebreak, entries held in a synchronous memory.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
  parameter int unsigned ENTRIES    = lfu_pkg::Entries,
  parameter int unsigned COUNT_BITS = lfu_pkg::CountBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action_i,
  input  logic signed [31:0]           key_i,
  input  logic signed [31:0]           value_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lfu_pkg::CapW-1:0]     cfg_data_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic signed [31:0]           read_value_o,
  output logic                         evicted_o,
  output logic signed [31:0]           evicted_key_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned AgeW = IdxW;
  localparam int unsigned RecW = 32 + 32 + COUNT_BITS + AgeW;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_VIC   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [CntW-1:0] ptr_q;        // issued read index (0..ENTRIES)
  logic [IdxW-1:0] ridx_q;       // index whose data is on rdata
  logic         rv_q;            // rdata valid this cycle
  logic [ENTRIES-1:0] valid_q;
  logic [lfu_pkg::CapW-1:0] cap_q;

  logic         act_q;
  logic [31:0]  key_q, val_q;
  logic         hit_q;
  logic [IdxW-1:0] hidx_q;
  logic [AgeW-1:0] hage_q;
  logic [31:0]  hval_q;
  logic         vic_q;
  logic [IdxW-1:0] vidx_q;
  logic [COUNT_BITS-1:0] vcnt_q;
  logic [AgeW-1:0] vage_q;
  logic [31:0]  vkey_q;
  logic         free_q;
  logic [IdxW-1:0] fidx_q;
  logic [CntW-1:0] occ_q;

  // plan decided after the match pass or the victim pass
  logic         mode_bump_q, mode_ins_q, do_evict_q;
  logic [IdxW-1:0] tgt_q;

  // memory
  logic         we;
  logic [IdxW-1:0] waddr, raddr;
  logic [RecW-1:0] wdata, rdata;
  logic [31:0]  r_key, r_val;
  logic [COUNT_BITS-1:0] r_cnt;
  logic [AgeW-1:0] r_age;

  assign {r_key, r_val, r_cnt, r_age} = rdata;

  lfu_mem #(.Width(RecW), .Depth(1 << IdxW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [CntW-1:0] cap_eff;
  assign cap_eff = (32'(cap_q) > 32'(ENTRIES)) ? CntW'(ENTRIES) : CntW'(cap_q);

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign raddr       = ptr_q[IdxW-1:0];

  logic last_issue;
  assign last_issue = (ptr_q == CntW'(ENTRIES));
  logic r_live;
  assign r_live = rv_q && valid_q[ridx_q];

  // a pass walks the memory; the update pass only when something changes
  logic scan;
  assign scan = (state_q == S_MATCH) || (state_q == S_VIC) ||
                (state_q == S_UPD && (mode_bump_q || mode_ins_q));

  logic pass_end;
  assign pass_end = rv_q && ridx_q == IdxW'(ENTRIES - 1);

  // match and occupancy including the entry on rdata
  logic hit_next;
  assign hit_next = hit_q || (r_live && r_key == key_q);
  logic [CntW-1:0] occ_next;
  assign occ_next = occ_q + CntW'(r_live);

  // victim comparison
  logic better;
  assign better = !vic_q || (r_cnt < vcnt_q) || (r_cnt == vcnt_q && r_age > vage_q);

  // age, count and value update during the write pass
  logic [AgeW-1:0] new_age;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [31:0]  new_val;
  always_comb begin
    new_age = r_age;
    new_cnt = r_cnt;
    new_val = r_val;
    if (mode_bump_q) begin
      if (ridx_q == tgt_q) begin
        new_age = '0;
        new_cnt = (r_cnt == CountMax) ? r_cnt : r_cnt + 1'b1;
        if (act_q == lfu_pkg::ACT_PUT) new_val = val_q;
      end else if (r_age < hage_q) begin
        new_age = r_age + 1'b1;
      end
    end else begin
      // insert, possibly after removing the victim at age vage_q
      if (do_evict_q && r_age > vage_q) new_age = r_age;
      else new_age = r_age + 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ridx_q;
    wdata = {r_key, new_val, new_cnt, new_age};
    if (state_q == S_UPD && r_live && !(mode_ins_q && ridx_q == tgt_q)) begin
      we = 1'b1;
    end
    if (state_q == S_DONE && mode_ins_q) begin
      we    = 1'b1;
      waddr = tgt_q;
      wdata = {key_q, val_q, COUNT_BITS'(1), AgeW'(0)};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_MATCH;
      S_MATCH: if (pass_end) begin
        if (act_q == lfu_pkg::ACT_PUT && cap_eff != '0 && !hit_next &&
            occ_next >= cap_eff) state_d = S_VIC;
        else state_d = S_UPD;
      end
      S_VIC:   if (pass_end) state_d = S_DONE - 3'd1;
      S_UPD:   if (!mode_bump_q && !mode_ins_q) state_d = S_DONE;
               else if (pass_end) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer and scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      rv_q    <= 1'b0;
      ridx_q  <= '0;
      valid_q <= '0;
      cap_q   <= lfu_pkg::CapReset;
      done_o  <= 1'b0;
      hit_q   <= 1'b0;
      vic_q   <= 1'b0;
      free_q  <= 1'b0;
      occ_q   <= '0;
      mode_bump_q <= 1'b0;
      mode_ins_q  <= 1'b0;
      do_evict_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == S_DONE);
      rv_q    <= scan && !last_issue;
      ridx_q  <= ptr_q[IdxW-1:0];
      if (pass_end) ptr_q <= '0;
      else if (scan && !last_issue) ptr_q <= ptr_q + 1'b1;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
      case (state_q)
        S_IDLE: if (start) begin
          hit_q <= 1'b0; vic_q <= 1'b0; free_q <= 1'b0; occ_q <= '0;
          mode_bump_q <= 1'b0; mode_ins_q <= 1'b0; do_evict_q <= 1'b0;
          act_q <= action_i; key_q <= key_i; val_q <= value_i;
        end
        S_MATCH: if (rv_q) begin
          occ_q <= occ_next;
          if (r_live && r_key == key_q) begin
            hit_q <= 1'b1; hidx_q <= ridx_q; hage_q <= r_age; hval_q <= r_val;
          end
          if (!valid_q[ridx_q] && !free_q) begin
            free_q <= 1'b1; fidx_q <= ridx_q;
          end
          if (pass_end) begin
            if (hit_next) begin
              mode_bump_q <= (act_q == lfu_pkg::ACT_GET) || cap_eff != '0;
              tgt_q <= (r_live && r_key == key_q) ? ridx_q : hidx_q;
            end else if (act_q == lfu_pkg::ACT_PUT && cap_eff != '0 &&
                         occ_next < cap_eff) begin
              mode_ins_q <= 1'b1;
              tgt_q <= (!valid_q[ridx_q] && !free_q) ? ridx_q : fidx_q;
            end
          end
        end
        S_VIC: if (r_live) begin
          if (better) begin
            vic_q <= 1'b1; vidx_q <= ridx_q; vcnt_q <= r_cnt;
            vage_q <= r_age; vkey_q <= r_key;
          end
          if (pass_end) begin
            mode_ins_q <= 1'b1; do_evict_q <= 1'b1;
            tgt_q <= better ? ridx_q : vidx_q;
          end
        end else if (pass_end) begin
          mode_ins_q <= vic_q || free_q; do_evict_q <= vic_q;
          tgt_q <= vic_q ? vidx_q : fidx_q;
        end
        S_UPD: ;
        S_DONE: begin
          if (mode_ins_q) valid_q[tgt_q] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE) begin
      found_o       <= hit_q;
      read_value_o  <= (hit_q && act_q == lfu_pkg::ACT_GET) ? hval_q : 32'hFFFF_FFFF;
      evicted_o     <= do_evict_q;
      evicted_key_o <= do_evict_q ? vkey_q : 32'd0;
    end
  end

  // checks
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done pulse too long");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy at done");
  a_evict_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_o |-> !found_o) else $error("evict on hit");
  a_get_noevict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && act_q == lfu_pkg::ACT_GET) |-> !mode_ins_q)
    else $error("get inserted");

endmodule

@@ rtl/lfu_mem.sv @@
// ----------------------------------------------------------------------------
// lfu_mem
// Simple dual-port synchronous entry store, registered read.
// ----------------------------------------------------------------------------
module lfu_mem #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
